/* hdl/jsu_pkg.sv */
// Shared types, constants and helpers for the JSON string unescaper.
package jsu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam int CODE_W = 21;
   localparam int CHAR_W = 32;
   localparam int UNIT_W = 16;
   localparam int STAT_W = 3;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
   localparam logic [STAT_W-1:0] ST_UNTERM  = 3'd1;
   localparam logic [STAT_W-1:0] ST_CTRL    = 3'd2;
   localparam logic [STAT_W-1:0] ST_BADESC  = 3'd3;
   localparam logic [STAT_W-1:0] ST_BADHEX  = 3'd4;
   localparam logic [STAT_W-1:0] ST_SHORT   = 3'd5;
   localparam logic [STAT_W-1:0] ST_MISSING = 3'd6;

   // characters of interest
   localparam logic [CODE_W-1:0] CH_SPACE     = 21'h20;
   localparam logic [CODE_W-1:0] CH_QUOTE     = 21'h22;
   localparam logic [CODE_W-1:0] CH_SLASH     = 21'h2F;
   localparam logic [CODE_W-1:0] CH_BACKSLASH = 21'h5C;
   localparam logic [CODE_W-1:0] CH_B         = 21'h62;
   localparam logic [CODE_W-1:0] CH_F         = 21'h66;
   localparam logic [CODE_W-1:0] CH_N         = 21'h6E;
   localparam logic [CODE_W-1:0] CH_R         = 21'h72;
   localparam logic [CODE_W-1:0] CH_T         = 21'h74;
   localparam logic [CODE_W-1:0] CH_U         = 21'h75;

   localparam logic [CHAR_W-1:0] VAL_BS  = 32'h08;
   localparam logic [CHAR_W-1:0] VAL_FF  = 32'h0C;
   localparam logic [CHAR_W-1:0] VAL_LF  = 32'h0A;
   localparam logic [CHAR_W-1:0] VAL_CR  = 32'h0D;
   localparam logic [CHAR_W-1:0] VAL_TAB = 32'h09;

   localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
   localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
   // 0x10000 - 0xDC00, folded offset of the pair merge
   localparam logic [CHAR_W-1:0] MERGE_BIAS = 32'h2400;

   // one queued command: a result, a surrogate pair, or a closing result
   typedef struct packed {
      logic [CHAR_W-1:0] val0;
      logic [UNIT_W-1:0] val1;
      logic              has_char;
      logic              pair;
      logic              last;
      logic [STAT_W-1:0] status;
   } cmd_type;

   // {valid, value} of an ASCII hex digit
   function automatic logic [4:0] hex_digit(logic [CODE_W-1:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= 21'h30 && c <= 21'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

/* hdl/json_string_unescape.sv */
// Top level of the streaming JSON string body unescaper.
//
// Usage: feed the characters of a JSON string body, one item per cycle on
// the req_ channel (valid/ready), starting just after the opening quote.
// Set req_end_of_text to mark that the text ran out. Decoded characters
// leave on the rsp_ channel; the closing quote, or the first fault, gives a
// final item with rsp_last set, rsp_has_char clear and the status code.
// After that final item the block swallows further items silently until
// reset. csr_wr_data written with csr_wr_en selects surrogate handling:
// 1 (reset value) merges a pair into one code point, 0 emits both halves.
//
// An accepted item's result passes the command queue, then the output register.
// Throughput: one item per cycle while the queue has room; a surrogate pair in
// narrow mode leaves as two items, absorbed by the queue (QUEUE_DEPTH entries).
// req_ready depends only on queue fill, so a stalled receiver lets the
// decoder run ahead until the queue is full, then backpressures.
// Reset (synchronous, active high) empties the queue, drops any pending
// result and returns the decoder to plain character mode.
module json_string_unescape #(
   parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [jsu_pkg::CODE_W-1:0] req_code_unit,
   input  logic                       req_end_of_text,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [jsu_pkg::CHAR_W-1:0] rsp_char_value,
   output logic                       rsp_has_char,
   output logic                       rsp_last,
   output logic [jsu_pkg::STAT_W-1:0] rsp_status,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data
);

   logic             wide_units_ff, wide_units_in;
   logic             take;
   logic             push;
   logic             pop;
   logic             q_full;
   logic             q_valid;
   jsu_pkg::cmd_type push_cmd;
   jsu_pkg::cmd_type head;

   // mode register; the user must write it only while idle, which the block does not enforce
   assign wide_units_in = csr_wr_en ? csr_wr_data : wide_units_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_units_ff <= 1'b1;
      end else begin
         wide_units_ff <= wide_units_in;
      end
   end

   // every accepted item has a queue slot for what it may produce
   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .code_unit   (req_code_unit),
      .end_of_text (req_end_of_text),
      .wide_units  (wide_units_ff),
      .push        (push),
      .cmd         (push_cmd)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (head)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_value (rsp_char_value),
      .rsp_has_char   (rsp_has_char),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

/* hdl/jsu_front.sv */
// Front end: per-character escape decoder that issues result commands.
module jsu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [jsu_pkg::CODE_W-1:0]    code_unit,
   input  logic                          end_of_text,
   input  logic                          wide_units,
   output logic                          push,
   output jsu_pkg::cmd_type              cmd
);

   typedef enum logic [6:0] {
      MODE_PLAIN  = 7'b0000001,
      MODE_ESC    = 7'b0000010,
      MODE_HEX1   = 7'b0000100,
      MODE_LOW_BS = 7'b0001000,
      MODE_LOW_U  = 7'b0010000,
      MODE_HEX2   = 7'b0100000,
      MODE_HALT   = 7'b1000000
   } mode_type;

   mode_type                       mode_ff, mode_in;
   logic [1:0]                     digit_ff, digit_in;
   logic [11:0]                    acc_ff, acc_in;
   logic [jsu_pkg::UNIT_W-1:0]     high_ff, high_in;

   logic [4:0]                     hex;
   logic [jsu_pkg::UNIT_W-1:0]     unit;
   logic [jsu_pkg::CHAR_W-1:0]     merged;

   assign hex    = jsu_pkg::hex_digit(code_unit);
   assign unit   = {acc_ff, hex[3:0]};
   assign merged = {12'd0, high_ff[9:0], 10'd0} + {16'd0, unit} + jsu_pkg::MERGE_BIAS;

   always_comb begin
      mode_in  = mode_ff;
      digit_in = digit_ff;
      acc_in   = acc_ff;
      high_in  = high_ff;
      push     = 1'b0;
      cmd      = '0;
      if (take && mode_ff != MODE_HALT) begin
         if (end_of_text) begin
            push = 1'b1; cmd.last = 1'b1; cmd.status = jsu_pkg::ST_UNTERM;
            mode_in = MODE_HALT;
         end else if (code_unit < jsu_pkg::CH_SPACE) begin
            push = 1'b1; cmd.last = 1'b1; cmd.status = jsu_pkg::ST_CTRL;
            mode_in = MODE_HALT;
         end else begin
            unique case (mode_ff)
               MODE_PLAIN: begin
                  if (code_unit == jsu_pkg::CH_BACKSLASH) begin
                     mode_in = MODE_ESC;
                  end else if (code_unit == jsu_pkg::CH_QUOTE) begin
                     push = 1'b1; cmd.last = 1'b1; cmd.status = jsu_pkg::ST_OK;
                     mode_in = MODE_HALT;
                  end else begin
                     push = 1'b1; cmd.has_char = 1'b1;
                     cmd.val0 = {11'd0, code_unit};
                  end
               end
               MODE_ESC: begin
                  push = 1'b1;
                  cmd.has_char = 1'b1;
                  mode_in = MODE_PLAIN;
                  unique case (code_unit)
                     jsu_pkg::CH_BACKSLASH,
                     jsu_pkg::CH_QUOTE,
                     jsu_pkg::CH_SLASH: cmd.val0 = {11'd0, code_unit};
                     jsu_pkg::CH_B:     cmd.val0 = jsu_pkg::VAL_BS;
                     jsu_pkg::CH_F:     cmd.val0 = jsu_pkg::VAL_FF;
                     jsu_pkg::CH_N:     cmd.val0 = jsu_pkg::VAL_LF;
                     jsu_pkg::CH_R:     cmd.val0 = jsu_pkg::VAL_CR;
                     jsu_pkg::CH_T:     cmd.val0 = jsu_pkg::VAL_TAB;
                     jsu_pkg::CH_U: begin
                        push     = 1'b0;
                        cmd      = '0;
                        acc_in   = '0;
                        digit_in = '0;
                        mode_in  = MODE_HEX1;
                     end
                     default: begin
                        cmd = '0; cmd.last = 1'b1; cmd.status = jsu_pkg::ST_BADESC;
                        mode_in = MODE_HALT;
                     end
                  endcase
               end
               MODE_HEX1, MODE_HEX2: begin
                  if (code_unit == jsu_pkg::CH_QUOTE) begin
                     push = 1'b1; cmd.last = 1'b1;
                     cmd.status = (mode_ff == MODE_HEX1) ? jsu_pkg::ST_SHORT
                                                         : jsu_pkg::ST_MISSING;
                     mode_in = MODE_HALT;
                  end else if (!hex[4]) begin
                     push = 1'b1; cmd.last = 1'b1; cmd.status = jsu_pkg::ST_BADHEX;
                     mode_in = MODE_HALT;
                  end else if (digit_ff != 2'd3) begin
                     acc_in   = unit[11:0];
                     digit_in = digit_ff + 2'd1;
                  end else if (mode_ff == MODE_HEX1) begin
                     if (unit >= jsu_pkg::HIGH_FIRST && unit <= jsu_pkg::HIGH_LAST) begin
                        high_in = unit;
                        mode_in = MODE_LOW_BS;
                     end else begin
                        push = 1'b1; cmd.has_char = 1'b1; cmd.val0 = {16'd0, unit};
                        mode_in = MODE_PLAIN;
                     end
                  end else begin
                     push = 1'b1; cmd.has_char = 1'b1;
                     mode_in = MODE_PLAIN;
                     if (wide_units) begin
                        cmd.val0 = merged;
                     end else begin
                        cmd.pair = 1'b1;
                        cmd.val0 = {16'd0, high_ff};
                        cmd.val1 = unit;
                     end
                  end
               end
               MODE_LOW_BS: begin
                  if (code_unit == jsu_pkg::CH_BACKSLASH) begin
                     mode_in = MODE_LOW_U;
                  end else begin
                     push = 1'b1; cmd.last = 1'b1; cmd.status = jsu_pkg::ST_MISSING;
                     mode_in = MODE_HALT;
                  end
               end
               MODE_LOW_U: begin
                  if (code_unit == jsu_pkg::CH_U) begin
                     acc_in   = '0;
                     digit_in = '0;
                     mode_in  = MODE_HEX2;
                  end else begin
                     push = 1'b1; cmd.last = 1'b1; cmd.status = jsu_pkg::ST_MISSING;
                     mode_in = MODE_HALT;
                  end
               end
               default: mode_in = MODE_HALT;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         digit_ff <= '0;
         acc_ff   <= '0;
         high_ff  <= '0;
      end else begin
         mode_ff  <= mode_in;
         digit_ff <= digit_in;
         acc_ff   <= acc_in;
         high_ff  <= high_in;
      end
   end

`ifndef SYNTHESIS
   // nothing is issued once the string has ended
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_HALT) |-> !push)
      else $error("front issued a command after the string ended");
`endif

endmodule

/* hdl/jsu_queue.sv */
// Small register queue between the decoder and the result stage.
module jsu_queue #(
   parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output jsu_pkg::cmd_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::cmd_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> not_empty)
      else $error("pop from an empty queue");
`endif

endmodule

/* hdl/jsu_back.sv */
// Back end: expands queued commands into result items behind an output register.
module jsu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  jsu_pkg::cmd_type           head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [jsu_pkg::CHAR_W-1:0] rsp_char_value,
   output logic                       rsp_has_char,
   output logic                       rsp_last,
   output logic [jsu_pkg::STAT_W-1:0] rsp_status
);

   logic                       valid_ff, valid_in;
   logic                       phase_ff, phase_in;
   logic                       load;
   logic [jsu_pkg::CHAR_W-1:0] value_ff, value_in;
   logic                       has_ff, last_ff;
   logic [jsu_pkg::STAT_W-1:0] status_ff;

   // output register free, or emptied this cycle
   assign load = q_valid && (!valid_ff || rsp_ready);

   always_comb begin
      phase_in = phase_ff;
      pop      = 1'b0;
      value_in = head.val0;
      if (load) begin
         if (head.pair && !phase_ff) begin
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            pop      = 1'b1;
            if (phase_ff) begin
               value_in = {16'd0, head.val1};
            end
         end
      end
      valid_in = load ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff  <= value_in;
         has_ff    <= head.has_char;
         last_ff   <= head.last;
         status_ff <= head.status;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_char_value = value_ff;
   assign rsp_has_char   = has_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;

`ifndef SYNTHESIS
   // second half pending: the pair stays at the head, first half is on the port
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> (q_valid && head.pair && valid_ff && has_ff))
      else $error("pair second half lost its queue entry");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the streaming JSON string unescaper.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Roughly this many random items follow the directed rows.
   localparam int RANDOM_ITEMS = 1700;
   // Phases of the random part; surrogate handling is rewritten between them.
   localparam int N_PHASES     = 6;
   // Items sent after the string has ended (no result is expected).
   localparam int N_AFTER_END  = 16;
   // Hard stop for a run that hangs.
   localparam int CYCLE_LIMIT  = 1_000_000;
   // Cycles to let the pipeline drain, with a margin.
   localparam int SETTLE       = 4;
   localparam int N_DIRECTED   = 26;

   localparam logic [jsu_pkg::CHAR_W-1:0] SURR_HIGH_BASE = 32'hD800;
   localparam logic [jsu_pkg::CHAR_W-1:0] SURR_LOW_BASE  = 32'hDC00;
   localparam logic [jsu_pkg::CHAR_W-1:0] SUPPLEMENTARY  = 32'h10000;

   // Where the decoder stands inside the character stream.
   typedef enum logic [2:0] {
      DM_PLAIN,       // ordinary characters
      DM_ESC,         // just saw a backslash
      DM_HEX_FIRST,   // hex digits of a \u escape
      DM_SEEK_BS,     // high half done, backslash of the low half due
      DM_SEEK_U,      // 'u' of the low half due
      DM_HEX_SECOND,  // hex digits of the low half
      DM_HALTED       // string over, everything ignored until reset
   } decode_mode_type;

   // How the one string of this run is brought to its end.
   typedef enum int {
      END_QUOTE,
      END_TEXT,
      END_CONTROL,
      END_BAD_ESCAPE,
      END_BAD_HEX_FIRST,
      END_SHORT,
      END_MISSING_HALF,
      END_BAD_HEX_SECOND
   } string_end_type;

   typedef struct packed {
      logic [jsu_pkg::CHAR_W-1:0] char_value;
      logic                       has_char;
      logic                       last;
      logic [jsu_pkg::STAT_W-1:0] status;
   } char_result_type;

   typedef struct packed {
      logic [jsu_pkg::CODE_W-1:0] code;
      logic                       typed;       // expected char given below, not predicted
      logic [jsu_pkg::CHAR_W-1:0] char_value;
   } stim_row_type;

   // Directed rows: range extremes, escapes and both \u flavors. Typed values
   // are the obvious ones; the surrogate pair decodes at reset (wide) mode.
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{jsu_pkg::CH_SPACE,     1'b1, 32'h20},      // lowest legal plain character
      '{21'h1FFFFF,            1'b1, 32'h1FFFFF},  // beyond Unicode, passed through
      '{jsu_pkg::CH_BACKSLASH, 1'b0, 32'h0},
      '{jsu_pkg::CH_QUOTE,     1'b1, 32'h22},
      '{jsu_pkg::CH_BACKSLASH, 1'b0, 32'h0},
      '{jsu_pkg::CH_SLASH,     1'b1, 32'h2F},
      '{jsu_pkg::CH_BACKSLASH, 1'b0, 32'h0},
      '{jsu_pkg::CH_B,         1'b1, jsu_pkg::VAL_BS},
      '{jsu_pkg::CH_BACKSLASH, 1'b0, 32'h0},       // \uffFF: mixed-case top of BMP
      '{jsu_pkg::CH_U,         1'b0, 32'h0},
      '{21'h66,                1'b0, 32'h0},
      '{21'h66,                1'b0, 32'h0},
      '{21'h46,                1'b0, 32'h0},
      '{21'h46,                1'b1, 32'hFFFF},
      '{jsu_pkg::CH_BACKSLASH, 1'b0, 32'h0},       // \udbFF\uDfff -> 0x10FFFF
      '{jsu_pkg::CH_U,         1'b0, 32'h0},
      '{21'h64,                1'b0, 32'h0},
      '{21'h62,                1'b0, 32'h0},
      '{21'h46,                1'b0, 32'h0},
      '{21'h46,                1'b0, 32'h0},
      '{jsu_pkg::CH_BACKSLASH, 1'b0, 32'h0},
      '{jsu_pkg::CH_U,         1'b0, 32'h0},
      '{21'h44,                1'b0, 32'h0},
      '{21'h66,                1'b0, 32'h0},
      '{21'h66,                1'b0, 32'h0},
      '{21'h66,                1'b1, 32'h10FFFF}
   };

   logic [jsu_pkg::CODE_W-1:0] escape_letters [8] = '{
      jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH, jsu_pkg::CH_B,
      jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R, jsu_pkg::CH_T
   };

   // DUT connections; every input has a known value from time zero.
   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic [jsu_pkg::CODE_W-1:0] req_code_unit   = '0;
   logic                       req_end_of_text = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b0;
   logic [jsu_pkg::CHAR_W-1:0] rsp_char_value;
   logic                       rsp_has_char;
   logic                       rsp_last;
   logic [jsu_pkg::STAT_W-1:0] rsp_status;
   logic                       csr_wr_en       = 1'b0;
   logic                       csr_wr_data     = 1'b0;

   // Decoder shadow state.
   decode_mode_type            dec_mode    = DM_PLAIN;
   int                         digit_count = 0;
   logic [jsu_pkg::UNIT_W-1:0] hex_acc     = '0;
   logic [jsu_pkg::UNIT_W-1:0] high_unit   = '0;
   logic                       wide_mode   = 1'b1;   // register comes up merging pairs

   char_result_type pending_chars [$];   // decoded items still owed by the DUT
   int              fail_count  = 0;
   int              items_sent  = 0;
   int              cycle_count = 0;
   int              send_calm   = 0;
   int              rsp_calm    = 0;
   int              rsp_hold    = 0;

   json_string_unescape u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_value  (rsp_char_value),
      .rsp_has_char    (rsp_has_char),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Only ASCII 0-9, a-f, A-F count as hex digits.
   function automatic int hex_nibble(logic [jsu_pkg::CODE_W-1:0] c);
      if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
      if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
      if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
      return -1;
   endfunction

   // Shadow of the decoder: advances state on one accepted item and gives
   // the zero, one or two results it owes.
   function automatic void decode_unit(input logic [jsu_pkg::CODE_W-1:0] code,
                                       input logic eot,
                                       output int n, output char_result_type r0,
                                       output char_result_type r1);
      logic                       ends;
      logic [jsu_pkg::STAT_W-1:0] fault;
      logic [jsu_pkg::CHAR_W-1:0] merged;
      int                         h;
      n = 0;
      r0 = '0;
      r1 = '0;
      ends = 1'b0;
      fault = jsu_pkg::ST_OK;
      h = hex_nibble(code);
      if (dec_mode == DM_HALTED) return;
      // end of text beats everything, then control chars in any mode
      if (eot) begin
         ends = 1'b1;
         fault = jsu_pkg::ST_UNTERM;
      end else if (code < jsu_pkg::CH_SPACE) begin
         ends = 1'b1;
         fault = jsu_pkg::ST_CTRL;
      end else begin
         case (dec_mode)
            DM_PLAIN: begin
               if (code == jsu_pkg::CH_BACKSLASH) dec_mode = DM_ESC;
               else if (code == jsu_pkg::CH_QUOTE) ends = 1'b1;
               else begin
                  n = 1;
                  r0 = '{32'(code), 1'b1, 1'b0, jsu_pkg::ST_OK};
               end
            end
            DM_ESC: begin
               dec_mode = DM_PLAIN;
               n = 1;
               r0 = '{32'h0, 1'b1, 1'b0, jsu_pkg::ST_OK};
               case (code)
                  jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH:
                     r0.char_value = 32'(code);
                  jsu_pkg::CH_B: r0.char_value = jsu_pkg::VAL_BS;
                  jsu_pkg::CH_F: r0.char_value = jsu_pkg::VAL_FF;
                  jsu_pkg::CH_N: r0.char_value = jsu_pkg::VAL_LF;
                  jsu_pkg::CH_R: r0.char_value = jsu_pkg::VAL_CR;
                  jsu_pkg::CH_T: r0.char_value = jsu_pkg::VAL_TAB;
                  jsu_pkg::CH_U: begin
                     n = 0;
                     hex_acc = '0;
                     digit_count = 0;
                     dec_mode = DM_HEX_FIRST;
                  end
                  default: begin
                     n = 0;
                     ends = 1'b1;
                     fault = jsu_pkg::ST_BADESC;
                  end
               endcase
            end
            DM_HEX_FIRST: begin
               if (code == jsu_pkg::CH_QUOTE) begin
                  ends = 1'b1;
                  fault = jsu_pkg::ST_SHORT;
               end else if (h < 0) begin
                  ends = 1'b1;
                  fault = jsu_pkg::ST_BADHEX;
               end else begin
                  hex_acc = {hex_acc[11:0], 4'(h)};
                  digit_count++;
                  if (digit_count == 4) begin
                     if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                        high_unit = hex_acc;
                        dec_mode = DM_SEEK_BS;
                     end else begin
                        dec_mode = DM_PLAIN;
                        n = 1;
                        r0 = '{32'(hex_acc), 1'b1, 1'b0, jsu_pkg::ST_OK};
                     end
                  end
               end
            end
            DM_SEEK_BS: begin
               if (code != jsu_pkg::CH_BACKSLASH) begin
                  ends = 1'b1;
                  fault = jsu_pkg::ST_MISSING;
               end else dec_mode = DM_SEEK_U;
            end
            DM_SEEK_U: begin
               if (code != jsu_pkg::CH_U) begin
                  ends = 1'b1;
                  fault = jsu_pkg::ST_MISSING;
               end else begin
                  hex_acc = '0;
                  digit_count = 0;
                  dec_mode = DM_HEX_SECOND;
               end
            end
            DM_HEX_SECOND: begin
               // a quote here means the low half is missing, not short
               if (code == jsu_pkg::CH_QUOTE) begin
                  ends = 1'b1;
                  fault = jsu_pkg::ST_MISSING;
               end else if (h < 0) begin
                  ends = 1'b1;
                  fault = jsu_pkg::ST_BADHEX;
               end else begin
                  hex_acc = {hex_acc[11:0], 4'(h)};
                  digit_count++;
                  if (digit_count == 4) begin
                     dec_mode = DM_PLAIN;
                     if (wide_mode) begin
                        // low half unchecked, so this wraps mod 2^32
                        merged = ((32'(high_unit) - SURR_HIGH_BASE) << 10)
                                 + (32'(hex_acc) - SURR_LOW_BASE) + SUPPLEMENTARY;
                        n = 1;
                        r0 = '{merged, 1'b1, 1'b0, jsu_pkg::ST_OK};
                     end else begin
                        n = 2;
                        r0 = '{32'(high_unit), 1'b1, 1'b0, jsu_pkg::ST_OK};
                        r1 = '{32'(hex_acc), 1'b1, 1'b0, jsu_pkg::ST_OK};
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (ends) begin
         dec_mode = DM_HALTED;
         n = 1;
         r0 = '{32'h0, 1'b0, 1'b1, fault};
      end
   endfunction

   // Mostly short gaps, a few long ones, and now and then a calm stretch.
   function automatic int next_pause(inout int calm);
      int gap;
      int r;
      gap = 0;
      if (calm > 0) calm--;
      else if ($urandom_range(0, 2) == 0) begin
         r = $urandom_range(0, 99);
         if (r < 75) gap = $urandom_range(1, 2);
         else if (r < 95) gap = $urandom_range(3, 6);
         else gap = $urandom_range(10, 40);
      end else if ($urandom_range(0, 24) == 0) calm = $urandom_range(30, 120);
      return gap;
   endfunction

   function automatic logic [jsu_pkg::CODE_W-1:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 21'h30 + 21'(nib);
      return ($urandom_range(0, 1) ? 21'h61 : 21'h41) + 21'(nib) - 21'd10;
   endfunction

   // Anything that is legal as a plain character: ASCII, Unicode, beyond.
   function automatic logic [jsu_pkg::CODE_W-1:0] random_plain();
      logic [jsu_pkg::CODE_W-1:0] c;
      int                         r;
      do begin
         r = $urandom_range(0, 99);
         if (r < 60) c = 21'($urandom_range(32'h20, 32'h7E));
         else if (r < 85) c = 21'($urandom_range(32'h80, 32'h10FFFF));
         else c = 21'($urandom_range(32'h110000, 32'h1FFFFF));
      end while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BACKSLASH);
      return c;
   endfunction

   function automatic logic [jsu_pkg::CODE_W-1:0] random_non_hex();
      logic [jsu_pkg::CODE_W-1:0] c;
      do begin
         c = $urandom_range(0, 3) != 0 ? 21'($urandom_range(32'h20, 32'h7E))
                                       : 21'($urandom_range(32'h80, 32'h1FFFFF));
      end while (hex_nibble(c) >= 0 || c == jsu_pkg::CH_QUOTE);
      return c;
   endfunction

   function automatic logic [jsu_pkg::UNIT_W-1:0] random_high();
      return 16'hD800 + 16'($urandom_range(0, 32'h3FF));
   endfunction

   function automatic logic [jsu_pkg::UNIT_W-1:0] random_bmp();
      logic [jsu_pkg::UNIT_W-1:0] v;
      do v = 16'($urandom_range(0, 32'hFFFF));
      while (v >= 16'hD800 && v <= 16'hDBFF);
      return v;
   endfunction

   // Presents one item and returns at the rising edge that accepts it.
   task automatic offer_unit(input logic [jsu_pkg::CODE_W-1:0] code, input logic eot);
      int gap;
      gap = next_pause(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_code_unit <= code;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_predicted(input logic [jsu_pkg::CODE_W-1:0] code, input logic eot);
      int              n;
      char_result_type r0;
      char_result_type r1;
      offer_unit(code, eot);
      decode_unit(code, eot, n, r0, r1);
      if (n > 0) pending_chars.push_back(r0);
      if (n > 1) pending_chars.push_back(r1);
      @(negedge clock);
   endtask

   // First k characters of the six that spell \uXXXX for value v.
   task automatic send_escape_prefix(input logic [jsu_pkg::UNIT_W-1:0] v, input int k);
      logic [jsu_pkg::CODE_W-1:0] c;
      for (int i = 0; i < k; i++) begin
         if (i == 0) c = jsu_pkg::CH_BACKSLASH;
         else if (i == 1) c = jsu_pkg::CH_U;
         else c = hex_char(v[15 - 4 * (i - 2) -: 4]);
         send_predicted(c, 1'b0);
      end
   endtask

   // One well-formed piece of text with random content.
   task automatic send_segment();
      int                         r;
      logic [jsu_pkg::UNIT_W-1:0] low;
      r = $urandom_range(0, 99);
      if (r < 40) send_predicted(random_plain(), 1'b0);
      else if (r < 65) begin
         send_predicted(jsu_pkg::CH_BACKSLASH, 1'b0);
         send_predicted(escape_letters[$urandom_range(0, 7)], 1'b0);
      end else if (r < 80) send_escape_prefix(random_bmp(), 6);
      else begin
         // the low half is not range-checked; out-of-range ones wrap the merge
         low = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 32'hFFFF))
                                         : 16'hDC00 + 16'($urandom_range(0, 32'h3FF));
         send_escape_prefix(random_high(), 6);
         send_escape_prefix(low, 6);
      end
   endtask

   // Leaves the decoder somewhere inside an escape (or in plain mode).
   task automatic send_partial_escape();
      if ($urandom_range(0, 1)) send_escape_prefix(random_bmp(), $urandom_range(0, 5));
      else begin
         send_escape_prefix(random_high(), 6);
         send_escape_prefix(16'($urandom_range(0, 32'hFFFF)), $urandom_range(0, 5));
      end
   endtask

   // The block halts for good on the end of its string, and reset comes only
   // once, so each run closes its one string in a randomly chosen way.
   task automatic close_string();
      string_end_type             how;
      logic [jsu_pkg::CODE_W-1:0] c;
      int                         j;
      how = string_end_type'($urandom_range(0, 7));
      case (how)
         END_QUOTE: send_predicted(jsu_pkg::CH_QUOTE, 1'b0);
         END_TEXT: begin
            send_partial_escape();
            send_predicted(21'($urandom_range(0, 32'h1FFFFF)), 1'b1);
         end
         END_CONTROL: begin
            // code 0 is a control char too, not an end mark
            send_partial_escape();
            send_predicted(21'($urandom_range(0, 32'h1F)), 1'b0);
         end
         END_BAD_ESCAPE: begin
            do c = $urandom_range(0, 3) != 0 ? 21'($urandom_range(32'h20, 32'h7E)) :
                                               random_plain();
            while (c == jsu_pkg::CH_BACKSLASH || c == jsu_pkg::CH_QUOTE ||
                   c == jsu_pkg::CH_SLASH || c == jsu_pkg::CH_B ||
                   c == jsu_pkg::CH_F || c == jsu_pkg::CH_N ||
                   c == jsu_pkg::CH_R || c == jsu_pkg::CH_T || c == jsu_pkg::CH_U);
            send_predicted(jsu_pkg::CH_BACKSLASH, 1'b0);
            send_predicted(c, 1'b0);
         end
         END_BAD_HEX_FIRST: begin
            send_escape_prefix(random_bmp(), $urandom_range(2, 5));
            send_predicted(random_non_hex(), 1'b0);
         end
         END_SHORT: begin
            send_escape_prefix(random_bmp(), $urandom_range(2, 5));
            send_predicted(jsu_pkg::CH_QUOTE, 1'b0);
         end
         END_MISSING_HALF: begin
            // wrong char where the backslash, the 'u' or a digit of the
            // low half belongs
            j = $urandom_range(0, 5);
            send_escape_prefix(random_high(), 6);
            send_escape_prefix(16'($urandom_range(0, 32'hFFFF)), j);
            c = jsu_pkg::CH_QUOTE;
            if (j < 2 && $urandom_range(0, 1)) begin
               do c = random_plain(); while (c == jsu_pkg::CH_U && j == 1);
            end
            send_predicted(c, 1'b0);
         end
         default: begin
            send_escape_prefix(random_high(), 6);
            send_escape_prefix(16'($urandom_range(0, 32'hFFFF)), $urandom_range(2, 5));
            send_predicted(random_non_hex(), 1'b0);
         end
      endcase
   endtask

   // Rewrites surrogate handling once the decoder has drained. The sender
   // holds off until every owed item is in, then waits out the SETTLE period,
   // since a half-finished escape may still be in flight without an owed item.
   task automatic write_wide(input logic value);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      wide_mode = value;
   endtask

   task automatic compare_field(input string field, input logic [jsu_pkg::CHAR_W-1:0] want,
                                input logic [jsu_pkg::CHAR_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   // Receiver: random back-pressure, changed on the falling edge.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_hold = next_pause(rsp_calm);
      end
   end

   // Checker: every accepted result against the oldest owed item.
   always @(posedge clock) begin
      char_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected item: char_value %0h has_char %0b last %0b status %0d",
                   rsp_char_value, rsp_has_char, rsp_last, rsp_status);
            fail_count++;
         end else begin
            want = pending_chars.pop_front();
            compare_field("char_value", want.char_value, rsp_char_value);
            compare_field("has_char", 32'(want.has_char), 32'(rsp_has_char));
            compare_field("last", 32'(want.last), 32'(rsp_last));
            compare_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("json_string_unescape test failed");
         $finish;
      end
   end

   initial begin
      int              n;
      char_result_type r0;
      char_result_type r1;
      int              phase_end;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed rows at the reset setting (pairs merged).
      for (int i = 0; i < N_DIRECTED; i++) begin
         offer_unit(directed_rows[i].code, 1'b0);
         decode_unit(directed_rows[i].code, 1'b0, n, r0, r1);
         if (directed_rows[i].typed) begin
            n = 1;
            r0 = '{directed_rows[i].char_value, 1'b1, 1'b0, jsu_pkg::ST_OK};
         end
         if (n > 0) pending_chars.push_back(r0);
         if (n > 1) pending_chars.push_back(r1);
         @(negedge clock);
      end

      // Random text in phases: narrow, wide, narrow, wide, then random.
      for (int ph = 0; ph < N_PHASES; ph++) begin
         write_wide(ph < 4 ? ph[0] : 1'($urandom_range(0, 1)));
         phase_end = N_DIRECTED + (ph + 1) * RANDOM_ITEMS / N_PHASES;
         while (items_sent < phase_end) send_segment();
      end

      close_string();

      // The block is halted now: these must all be swallowed silently.
      for (int i = 0; i < N_AFTER_END; i++) begin
         send_predicted(21'($urandom_range(0, 32'h1FFFFF)), i[0]);
      end
      req_valid <= 1'b0;

      while (pending_chars.size() != 0) @(negedge clock);
      repeat (3 * SETTLE) @(negedge clock);
      if (fail_count == 0) begin
         $display("json_string_unescape test passed");
      end else begin
         $display("json_string_unescape test failed");
      end
      $finish;
   end

endmodule
